// ----- rtl/snat_pkg.sv -----
// Shared types, register indexes and checksum helpers for the static NAT rewrite.
// Used by every module of the block; depends on nothing.
package snat_pkg;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_INSIDE_A = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROUTER_A = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_INSIDE_B = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROUTER_B = 8'd3;

	// Protocol numbers that carry a pseudo-header checksum
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [15:0] CSUM_ONES = 16'hffff;

	// Queue between classifier and checksum pipeline
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Classified header, as it leaves the front end
	typedef struct packed {
		logic        hit;
		logic        l4;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] nsrc;
		logic [31:0] ndst;
		logic [15:0] hcs;
		logic [15:0] tcs;
	} snat_item_t;

	// Finished result
	typedef struct packed {
		logic        matched;
		logic        transport_updated;
		logic [31:0] new_source;
		logic [31:0] new_dest;
		logic [15:0] new_header_checksum;
		logic [15:0] new_transport_checksum;
	} snat_result_t;

	// One 16-bit half: subtract old with end-around borrow, add new, fold, complement
	function automatic logic [15:0] update_half(input logic [15:0] csum,
			input logic [15:0] old_half, input logic [15:0] new_half);
		logic [15:0] s;
		logic [16:0] d;
		logic [16:0] t;
		logic [16:0] t1;
		logic [15:0] t2;
		s = ~csum;
		if (s >= old_half) begin
			d = {1'b0, s} - {1'b0, old_half};
		end else begin
			d = {1'b0, s} + {1'b0, CSUM_ONES} - {1'b0, old_half};
		end
		t  = {1'b0, d[15:0]} + {1'b0, new_half};
		t1 = {16'd0, t[16]} + {1'b0, t[15:0]};
		t2 = t1[15:0] + {15'd0, t1[16]};
		return ~t2;
	endfunction

	// Both halves of one address, high half first; a zero result reads as all ones
	function automatic logic [15:0] update_addr(input logic [15:0] csum,
			input logic [31:0] old_addr, input logic [31:0] new_addr);
		logic [15:0] c;
		c = update_half(csum, old_addr[31:16], new_addr[31:16]);
		c = update_half(c, old_addr[15:0], new_addr[15:0]);
		if (c == 16'd0) begin
			c = CSUM_ONES;
		end
		return c;
	endfunction

endpackage

// ----- rtl/snat_front.sv -----
// Front end: translation rule registers, rule match and transport classification.
// Depends on snat_pkg.
module snat_front (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [snat_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [31:0]                        cfg_data,
	// incoming header
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [31:0]                        source_address,
	input  logic [31:0]                        dest_address,
	input  logic [7:0]                         protocol,
	input  logic [12:0]                        fragment_offset,
	input  logic [15:0]                        header_checksum,
	input  logic [15:0]                        transport_checksum,
	// classified item toward the queue
	output logic                               out_valid,
	input  logic                               out_ready,
	output snat_pkg::snat_item_t               out_item
);

	logic [31:0] inside_a_q, router_a_q, inside_b_q, router_b_q;
	logic        valid_s1;
	snat_pkg::snat_item_t item_s1;
	snat_pkg::snat_item_t item_d;
	logic        hit_a, hit_b, l4_proto;

	assign cfg_ready = 1'b1;

	// Rule registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_a_q <= '0;
			router_a_q <= '0;
			inside_b_q <= '0;
			router_b_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				snat_pkg::CFG_INSIDE_A: inside_a_q <= cfg_data;
				snat_pkg::CFG_ROUTER_A: router_a_q <= cfg_data;
				snat_pkg::CFG_INSIDE_B: inside_b_q <= cfg_data;
				snat_pkg::CFG_ROUTER_B: router_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Rule match, A rule first
	always_comb begin
		hit_a    = (source_address == inside_a_q) && (dest_address == router_a_q);
		hit_b    = (source_address == inside_b_q) && (dest_address == router_b_q);
		l4_proto = (protocol == snat_pkg::PROTO_TCP) || (protocol == snat_pkg::PROTO_UDP);
		item_d.src  = source_address;
		item_d.dst  = dest_address;
		item_d.hcs  = header_checksum;
		item_d.tcs  = transport_checksum;
		item_d.hit  = hit_a || hit_b;
		item_d.l4   = (hit_a || hit_b) && l4_proto && (fragment_offset == 13'd0);
		if (hit_a) begin
			item_d.nsrc = router_b_q;
			item_d.ndst = inside_b_q;
		end else if (hit_b) begin
			item_d.nsrc = router_a_q;
			item_d.ndst = inside_a_q;
		end else begin
			item_d.nsrc = source_address;
			item_d.ndst = dest_address;
		end
	end

	// Stage register; refills as it drains
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

// ----- rtl/snat_queue.sv -----
// Short queue of classified items between the front end and the checksum pipeline.
// Depends on snat_pkg.
module snat_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  snat_pkg::snat_item_t  push_item,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output snat_pkg::snat_item_t  pop_item
);

	snat_pkg::snat_item_t         mem_q [snat_pkg::QUEUE_DEPTH];
	logic [snat_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [snat_pkg::QCNT_W-1:0]  count_q;
	logic                         do_push, do_pop;

	assign push_ready = (count_q != snat_pkg::QCNT_W'(snat_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == snat_pkg::QPTR_W'(snat_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == snat_pkg::QPTR_W'(snat_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/snat_back.sv -----
// Back end: two-stage incremental checksum update, source address then destination.
// Depends on snat_pkg; the last stage is the output register.
module snat_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  snat_pkg::snat_item_t   in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output snat_pkg::snat_result_t out_result
);

	logic                 valid_s2, valid_s3;
	logic                 ready_s2, ready_s3;
	snat_pkg::snat_item_t item_d2;
	snat_pkg::snat_item_t item_s2;
	snat_pkg::snat_result_t res_s3;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign in_ready = ready_s2;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= in_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Source address update on both checksums
	always_comb begin
		item_d2 = in_item;
		if (in_item.hit) begin
			item_d2.hcs = snat_pkg::update_addr(in_item.hcs, in_item.src, in_item.nsrc);
		end
		if (in_item.l4) begin
			item_d2.tcs = snat_pkg::update_addr(in_item.tcs, in_item.src, in_item.nsrc);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && in_valid) begin
			item_s2 <= item_d2;
		end
	end

	// Destination address update, result register
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			res_s3.matched           <= item_s2.hit;
			res_s3.transport_updated <= item_s2.l4;
			res_s3.new_source        <= item_s2.nsrc;
			res_s3.new_dest          <= item_s2.ndst;
			res_s3.new_header_checksum <= item_s2.hit
				? snat_pkg::update_addr(item_s2.hcs, item_s2.dst, item_s2.ndst)
				: item_s2.hcs;
			res_s3.new_transport_checksum <= item_s2.l4
				? snat_pkg::update_addr(item_s2.tcs, item_s2.dst, item_s2.ndst)
				: item_s2.tcs;
		end
	end

	assign out_valid  = valid_s3;
	assign out_result = res_s3;

endmodule

// ----- rtl/static_nat_rewrite_incremental_checksum.sv -----
// Top level of the static two-rule NAT rewrite with incremental checksum update.
// Depends on snat_pkg, snat_front, snat_queue and snat_back.
//
//   channel  direction  handshake           payload
//   s_*      in         s_tvalid/s_tready   s_tdata: IPv4 header fields
//   m_*      out        m_tvalid/m_tready   m_tdata: rewritten fields, m_tuser: flags
//   cfg_*    in         cfg_valid/cfg_ready cfg_index, cfg_data: rule register write
//
// One header per cycle sustained while m_tready stays high; a header passes the match
// stage, the queue, the source update and the destination update on its way to m_tdata.
// The checksum pipeline sets the rate: two half-word updates per stage and checksum.
// Reset clears the rule registers to zero and empties every stage and the queue.
// A stall on the master side fills the back end and the 2-entry queue first;
// s_tready drops only when the match stage cannot drain.
module static_nat_rewrite_incremental_checksum (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// source_address, dest_address, protocol, fragment_offset,
	// header_checksum, transport_checksum, 3 zero pad bits
	input  logic [119:0]                     s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// new_source, new_dest, new_header_checksum, new_transport_checksum
	output logic [95:0]                      m_tdata,
	// matched, transport_updated
	output logic [1:0]                       m_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [snat_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                      cfg_data
);

	logic                   fq_valid, fq_ready;
	logic                   qb_valid, qb_ready;
	snat_pkg::snat_item_t   fq_item, qb_item;
	snat_pkg::snat_result_t result;

	// Classify
	snat_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (s_tvalid),
		.in_ready           (s_tready),
		.source_address     (s_tdata[31:0]),
		.dest_address       (s_tdata[63:32]),
		.protocol           (s_tdata[71:64]),
		.fragment_offset    (s_tdata[84:72]),
		.header_checksum    (s_tdata[100:85]),
		.transport_checksum (s_tdata[116:101]),
		.out_valid          (fq_valid),
		.out_ready          (fq_ready),
		.out_item           (fq_item)
	);

	// Decouple
	snat_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_item   (qb_item)
	);

	// Update checksums
	snat_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (qb_valid),
		.in_ready   (qb_ready),
		.in_item    (qb_item),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	// Result packing
	assign m_tdata = {result.new_transport_checksum, result.new_header_checksum,
		result.new_dest, result.new_source};
	assign m_tuser = {result.transport_updated, result.matched};

endmodule
